@@ rtl/bmes_pkg.sv @@
// Package with the shared types and constants of the emboss bump shader.
package bmes_pkg;

    localparam int unsigned LIGHT_W = 9;
    localparam int unsigned NZ_W    = 11;
    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned PIX_W   = 8;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_LIGHT_X      = 3'd0;
    localparam logic [2:0] REG_LIGHT_Y      = 3'd1;
    localparam logic [2:0] REG_LIGHT_Z      = 3'd2;
    localparam logic [2:0] REG_NORMAL_Z     = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;
    localparam logic [2:0] REG_TEXTURE_MODE = 3'd6;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_GRAD  = 7'b0000100,
        ST_DOT   = 7'b0001000,
        ST_NORM  = 7'b0010000,
        ST_SRCH  = 7'b0100000,
        ST_COLOR = 7'b1000000
    } t_state;

endpackage

@@ rtl/bmes_ram.sv @@
// Generic single-port RAM with registered read.
module bmes_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ rtl/bump_map_emboss_shader_unit.sv @@
// Top level of the emboss bump shader: window, gradients and iterative shade search.
module bump_map_emboss_shader_unit
    import bmes_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_bump_pixel,
    input  logic [7:0]  i_tex_red,
    input  logic [7:0]  i_tex_green,
    input  logic [7:0]  i_tex_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_end_of_image
);
    // A border pixel passes the line-store read and the gradient, then goes idle,
    // an interior pixel with a flat gradient goes from the first dot step to the
    // color step, and any other interior pixel passes the line-store read, the
    // gradient, four multiply steps for the dot product and its square, four steps
    // for the squared norm and the search setup, sixteen steps for the eight-bit
    // shade search (one for t*t and one for the compare of each bit), the color step
    // and the return to idle. The result sits in an output register, and the next
    // pixel is taken once that register is free or being drained. Configuration
    // writes are taken only while idle and take precedence over a waiting pixel.

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

    t_state r_state, n_state;

    logic signed [8:0]  r_lx, r_ly, r_lz;
    logic [10:0]        r_nz, r_w, r_h;
    logic               r_tex;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_c;
    logic [RW-1:0] r_r;
    logic [7:0]    r_win [6];
    logic [7:0]    r_lo, r_tr, r_tg, r_tb;

    logic [7:0] w_up, w_mid;

    logic signed [10:0] r_nx, r_ny;
    logic signed [23:0] r_d;
    logic [22:0]        r_s;
    logic [45:0]        r_d2;
    logic [7:0]         r_q;
    logic [2:0]         r_bit;
    logic [1:0]         r_sub;
    logic [15:0]        r_tt;
    logic [7:0]         w_shade;
    logic               r_flat, r_eoi, r_emit;

    logic [10:0] w_w, w_h;
    logic [CW-1:0] w_cwrap;
    logic [RW-1:0] w_rwrap;
    logic          w_accept;

    // Clamp sizes to 3..MAX.
    always_comb begin
        if (r_w < 11'd3) w_w = 11'd3;
        else if (32'(r_w) > MAX_WIDTH) w_w = 11'(MAX_WIDTH);
        else w_w = r_w;
        if (r_h < 11'd3) w_h = 11'd3;
        else if (32'(r_h) > MAX_HEIGHT) w_h = 11'(MAX_HEIGHT);
        else w_h = r_h;
    end

    // Position of the incoming pixel after wrap of a changed size.
    always_comb begin
        logic [RW:0] rr;
        rr = {1'b0, r_row};
        w_cwrap = r_col;
        if (32'(r_col) >= 32'(w_w)) begin
            w_cwrap = '0;
            rr = rr + 1'b1;
        end
        if (32'(rr) >= 32'(w_h)) rr = '0;
        w_rwrap = rr[RW-1:0];
    end

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_ready     = (r_state == ST_IDLE) && (!o_valid || i_ready) && !i_cfg_valid;
    assign w_accept    = i_valid && o_ready;

    logic [AW-1:0] w_addr;
    logic          w_we;
    assign w_addr = w_accept ? w_cwrap[AW-1:0] : r_c[AW-1:0];
    assign w_we   = (r_state == ST_READ);

    bmes_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_mid), .o_rdata(w_up));
    bmes_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(r_lo), .o_rdata(w_mid));

    // Shared multiplier: one signed 25x25 product a step.
    logic signed [24:0] r_ma, r_mb;
    logic signed [49:0] w_prod;
    assign w_prod = r_ma * r_mb;

    // Search product t*t*s in two steps: t*t is registered, then times s for the compare.
    logic [15:0] w_t;
    logic [38:0] w_ts;
    assign w_t  = {8'd0, r_q | (8'h80 >> r_bit)};

    always_comb begin
        if (r_flat) w_shade = r_lz[7:0];
        else if (r_d[23]) w_shade = 8'd0;
        else w_shade = r_q;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_READ;
            ST_READ:  n_state = ST_GRAD;
            ST_GRAD:  n_state = ST_DOT;
            ST_DOT:   if (r_sub == 2'd3) n_state = ST_NORM;
            ST_NORM:  if (r_sub == 2'd3) n_state = ST_SRCH;
            ST_SRCH:  if (r_sub == 2'd1 && r_bit == 3'd7) n_state = ST_COLOR;
            ST_COLOR: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
        if (r_state == ST_GRAD && !r_emit) n_state = ST_IDLE;
        if (r_state == ST_DOT && r_flat) n_state = ST_COLOR;
    end

    logic [10:0] w_lsum, w_rsum, w_tsum, w_bsum;
    always_comb begin
        w_lsum = 11'(r_win[0]) + 11'(r_win[1]) + 11'(r_win[2]);
        w_rsum = 11'(w_up) + 11'(w_mid) + 11'(r_lo);
        w_tsum = 11'(r_win[0]) + 11'(r_win[3]) + 11'(w_up);
        w_bsum = 11'(r_win[2]) + 11'(r_win[5]) + 11'(r_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lx <= '0; r_ly <= '0; r_lz <= 9'sd255;
            r_nz <= 11'd510; r_w <= 11'd1024; r_h <= 11'd1024; r_tex <= 1'b0;
            r_col <= '0; r_row <= '0;
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
            o_valid <= 1'b0;
            r_sub <= '0; r_bit <= '0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LIGHT_X:      r_lx  <= i_cfg_data[8:0];
                    REG_LIGHT_Y:      r_ly  <= i_cfg_data[8:0];
                    REG_LIGHT_Z:      r_lz  <= i_cfg_data[8:0];
                    REG_NORMAL_Z:     r_nz  <= i_cfg_data[10:0];
                    REG_IMAGE_WIDTH:  r_w   <= i_cfg_data[10:0];
                    REG_IMAGE_HEIGHT: r_h   <= i_cfg_data[10:0];
                    REG_TEXTURE_MODE: r_tex <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_c  <= w_cwrap; r_r <= w_rwrap;
                        r_lo <= i_bump_pixel;
                        r_tr <= i_tex_red; r_tg <= i_tex_green; r_tb <= i_tex_blue;
                        r_emit <= (w_cwrap >= CW'(2)) && (w_rwrap >= RW'(2));
                        r_eoi <= (32'(w_cwrap) == 32'(w_w) - 1) &&
                                 (32'(w_rwrap) == 32'(w_h) - 1);
                    end
                end
                ST_READ: begin
                    // Line stores are written this cycle; window and counters advance.
                    r_nx <= $signed(w_lsum) - $signed(w_rsum);
                    r_ny <= $signed(w_bsum) - $signed(w_tsum);
                    r_win[0] <= r_win[3]; r_win[1] <= r_win[4]; r_win[2] <= r_win[5];
                    r_win[3] <= w_up; r_win[4] <= w_mid; r_win[5] <= r_lo;
                    if (32'(r_c) + 1 >= 32'(w_w)) begin
                        r_col <= '0;
                        r_row <= (32'(r_r) + 1 >= 32'(w_h)) ? '0 : r_r + 1'b1;
                    end else begin
                        r_col <= r_c + 1'b1;
                        r_row <= r_r;
                    end
                end
                ST_GRAD: begin
                    r_flat <= (r_nx == 0) && (r_ny == 0);
                    r_sub  <= '0;
                    r_ma   <= 25'(r_nx);
                    r_mb   <= 25'(r_lx);
                    r_d    <= '0;
                end
                ST_DOT: begin
                    // Accumulate nx*lx, ny*ly, nz*lz; last step forms d*d.
                    r_sub <= r_sub + 1'b1;
                    case (r_sub)
                        2'd0: begin
                            r_d <= 24'(w_prod);
                            r_ma <= 25'(r_ny); r_mb <= 25'(r_ly);
                        end
                        2'd1: begin
                            r_d <= r_d + 24'(w_prod);
                            r_ma <= $signed({14'd0, r_nz}); r_mb <= 25'(r_lz);
                        end
                        2'd2: begin
                            r_d <= r_d + 24'(w_prod);
                            r_ma <= 25'(r_d + 24'(w_prod));
                            r_mb <= 25'(r_d + 24'(w_prod));
                        end
                        default: begin
                            r_d2 <= 46'(w_prod);
                            r_ma <= 25'(r_nx); r_mb <= 25'(r_nx);
                        end
                    endcase
                end
                ST_NORM: begin
                    // The step counter wraps to zero on the last step.
                    r_sub <= r_sub + 1'b1;
                    case (r_sub)
                        2'd0: begin
                            r_s <= 23'(w_prod);
                            r_ma <= 25'(r_ny); r_mb <= 25'(r_ny);
                        end
                        2'd1: begin
                            r_s <= r_s + 23'(w_prod);
                            r_ma <= $signed({14'd0, r_nz});
                            r_mb <= $signed({14'd0, r_nz});
                        end
                        2'd2: r_s <= r_s + 23'(w_prod);
                        default: begin
                            r_q <= '0; r_bit <= '0;
                        end
                    endcase
                end
                ST_SRCH: begin
                    if (r_sub == 2'd0) begin
                        r_tt  <= w_t * w_t;
                        r_sub <= 2'd1;
                    end else begin
                        if (!r_d[23] && {23'd0, w_ts} <= {16'd0, r_d2})
                            r_q <= r_q | (8'h80 >> r_bit);
                        r_bit <= r_bit + 1'b1;
                        r_sub <= 2'd0;
                    end
                end
                ST_COLOR: begin
                    if (r_tex) begin
                        o_out_red   <= 8'((16'(r_tr) * 16'(w_shade)) >> 8);
                        o_out_green <= 8'((16'(r_tg) * 16'(w_shade)) >> 8);
                        o_out_blue  <= 8'((16'(r_tb) * 16'(w_shade)) >> 8);
                    end else begin
                        o_out_red <= w_shade; o_out_green <= w_shade;
                        o_out_blue <= w_shade;
                    end
                    o_end_of_image <= r_eoi;
                    o_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign w_ts = 39'(r_tt) * 39'(r_s);

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
    a_result_from_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_COLOR)) else $error("stray result");
    a_cfg_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_state == ST_IDLE)) else $error("config while busy");
`endif

endmodule
